// ===== rtl/evr_pkg.sv =====
package evr_pkg;

  localparam int TRIG_TABLE_ADDR_BITS_DEF = 10;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [15:0] trig_t;
  typedef logic signed [31:0] mat_t;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               saturated;
  } out_item_t;

  // Quarter-wave sine entry in Q1.14, built from a Q30 Taylor series.
  function automatic logic [14:0] sine_entry(input int idx, input int bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint s;
    longint q;
    x = (HALF_PI_Q30 * longint'(idx) + (64'd1 << (bits - 1))) >> bits;
    x2 = (x * x) >> 30;
    t = x;
    s = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      t = (t * x2) >> 30;
      case (n)
        1: t = t / 6;
        2: t = t / 20;
        3: t = t / 42;
        4: t = t / 72;
        5: t = t / 110;
        6: t = t / 156;
        7: t = t / 210;
        default: t = t / 272;
      endcase
      if (n % 2 == 1) s = s - longint'(t);
      else s = s + longint'(t);
    end
    if (s < 0) s = 0;
    q = (s + 32768) >>> 16;
    if (q > 16384) q = 16384;
    return q[14:0];
  endfunction

endpackage

// ===== rtl/euler_xyz_vector_rotate.sv =====
// Channel  Direction  Payload                     Handshake
// in_      input      vector and three angles     in_valid / in_stall
// out_     output     rotated vector, saturated   out_valid / out_stall
//
// One transfer per cycle is accepted while in_stall is low. Each item passes
// through the table read, two product stages, the row product and row sum
// stages, and the output register.
// A synchronous active-low reset clears all valid flags.
// The whole pipeline holds while the output register is full and stalled.
module euler_xyz_vector_rotate #(
  parameter int TRIG_TABLE_ADDR_BITS = evr_pkg::TRIG_TABLE_ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  evr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output evr_pkg::out_item_t out_data
);
  logic en;
  logic [4:0] vld_r;
  logic out_valid_r;
  evr_pkg::out_item_t out_data_r;

  evr_pkg::trig_t sx, cx, sy, cy, sz, cz;
  logic signed [31:0] vx1_r, vy1_r, vz1_r, vx2_r, vy2_r, vz2_r, vx3_r, vy3_r, vz3_r;
  logic signed [31:0] cycz_r, cysz_r, cxsz_r, cxcz_r, cysx_r, sxsz_r, czsx_r, cxcy_r;
  logic signed [31:0] sxsy_r, cxsy_r;
  evr_pkg::trig_t sy2_r, sz2_r, cz2_r;
  logic signed [47:0] t1, t2, t3, t4;
  evr_pkg::mat_t m00_r, m01_r, m02_r, m10_r, m11_r, m12_r, m20_r, m21_r, m22_r;
  logic signed [31:0] rx, ry, rz;
  logic sat_x, sat_y, sat_z;

  assign en = !out_valid_r || !out_stall;
  assign in_stall = !en;

  evr_trig_lane #(.TRIG_TABLE_ADDR_BITS(TRIG_TABLE_ADDR_BITS)) u_sx (
    .clk, .en, .phase(in_data.angle_x), .value(sx));
  evr_trig_lane #(.TRIG_TABLE_ADDR_BITS(TRIG_TABLE_ADDR_BITS)) u_cx (
    .clk, .en, .phase(in_data.angle_x + 16'h4000), .value(cx));
  evr_trig_lane #(.TRIG_TABLE_ADDR_BITS(TRIG_TABLE_ADDR_BITS)) u_sy (
    .clk, .en, .phase(in_data.angle_y), .value(sy));
  evr_trig_lane #(.TRIG_TABLE_ADDR_BITS(TRIG_TABLE_ADDR_BITS)) u_cy (
    .clk, .en, .phase(in_data.angle_y + 16'h4000), .value(cy));
  evr_trig_lane #(.TRIG_TABLE_ADDR_BITS(TRIG_TABLE_ADDR_BITS)) u_sz (
    .clk, .en, .phase(in_data.angle_z), .value(sz));
  evr_trig_lane #(.TRIG_TABLE_ADDR_BITS(TRIG_TABLE_ADDR_BITS)) u_cz (
    .clk, .en, .phase(in_data.angle_z + 16'h4000), .value(cz));

  assign t1 = 48'(sxsy_r) * 48'(cz2_r) + 48'sd8192;
  assign t2 = 48'(sxsy_r) * 48'(sz2_r) + 48'sd8192;
  assign t3 = -(48'(cxsy_r) * 48'(cz2_r)) + 48'sd8192;
  assign t4 = 48'(cxsy_r) * 48'(sz2_r) + 48'sd8192;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
      out_valid_r <= vld_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx1_r <= in_data.vec_x;
      vy1_r <= in_data.vec_y;
      vz1_r <= in_data.vec_z;
      vx2_r <= vx1_r;
      vy2_r <= vy1_r;
      vz2_r <= vz1_r;
      vx3_r <= vx2_r;
      vy3_r <= vy2_r;
      vz3_r <= vz2_r;
      cycz_r <= 32'(cy) * 32'(cz);
      cysz_r <= 32'(cy) * 32'(sz);
      cxsz_r <= 32'(cx) * 32'(sz);
      cxcz_r <= 32'(cx) * 32'(cz);
      cysx_r <= 32'(cy) * 32'(sx);
      sxsz_r <= 32'(sx) * 32'(sz);
      czsx_r <= 32'(cz) * 32'(sx);
      cxcy_r <= 32'(cx) * 32'(cy);
      sxsy_r <= 32'(sx) * 32'(sy);
      cxsy_r <= 32'(cx) * 32'(sy);
      sy2_r <= sy;
      sz2_r <= sz;
      cz2_r <= cz;
      m00_r <= cycz_r;
      m01_r <= -cysz_r;
      m02_r <= 32'(sy2_r) <<< 14;
      m10_r <= 32'(t1 >>> 14) + cxsz_r;
      m11_r <= cxcz_r - 32'(t2 >>> 14);
      m12_r <= -cysx_r;
      m20_r <= 32'(t3 >>> 14) + sxsz_r;
      m21_r <= czsx_r + 32'(t4 >>> 14);
      m22_r <= cxcy_r;
      out_data_r <= '{rot_x: rx, rot_y: ry, rot_z: rz, saturated: sat_x | sat_y | sat_z};
    end
  end

  evr_row_lane u_row_x (.clk, .en, .m0(m00_r), .m1(m01_r), .m2(m02_r),
    .v0(vx3_r), .v1(vy3_r), .v2(vz3_r), .rot(rx), .sat(sat_x));
  evr_row_lane u_row_y (.clk, .en, .m0(m10_r), .m1(m11_r), .m2(m12_r),
    .v0(vx3_r), .v1(vy3_r), .v2(vz3_r), .rot(ry), .sat(sat_y));
  evr_row_lane u_row_z (.clk, .en, .m0(m20_r), .m1(m21_r), .m2(m22_r),
    .v0(vx3_r), .v1(vy3_r), .v2(vz3_r), .rot(rz), .sat(sat_z));

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
endmodule

// ===== rtl/evr_trig_lane.sv =====
module evr_trig_lane #(
  parameter int TRIG_TABLE_ADDR_BITS = evr_pkg::TRIG_TABLE_ADDR_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  logic [15:0]   phase,
  output evr_pkg::trig_t value
);
  localparam int N = 1 << TRIG_TABLE_ADDR_BITS;
  localparam int AW = TRIG_TABLE_ADDR_BITS + 1;

  logic [14:0] rom [0:N];
  logic [TRIG_TABLE_ADDR_BITS-1:0] idx;
  logic [AW-1:0] addr;
  logic [14:0] mag_r;
  logic neg_r;

  for (genvar gi = 0; gi <= N; gi++) begin : g_rom
    assign rom[gi] = evr_pkg::sine_entry(gi, TRIG_TABLE_ADDR_BITS);
  end

  assign idx = phase[13:14-TRIG_TABLE_ADDR_BITS];
  assign addr = phase[14] ? AW'(N) - {1'b0, idx} : {1'b0, idx};

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= rom[addr];
      neg_r <= phase[15];
    end
  end

  assign value = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
endmodule

// ===== rtl/evr_row_lane.sv =====
module evr_row_lane (
  input  logic               clk,
  input  logic               en,
  input  evr_pkg::mat_t      m0,
  input  evr_pkg::mat_t      m1,
  input  evr_pkg::mat_t      m2,
  input  logic signed [31:0] v0,
  input  logic signed [31:0] v1,
  input  logic signed [31:0] v2,
  output logic signed [31:0] rot,
  output logic               sat
);
  logic signed [63:0] p0_r, p1_r, p2_r;
  logic signed [63:0] acc;
  logic signed [35:0] r;
  logic signed [31:0] rot_nxt;
  logic sat_nxt;
  logic signed [31:0] rot_r;
  logic sat_r;

  assign acc = p0_r + p1_r + p2_r + 64'sd134217728;
  assign r = 36'(acc >>> 28);

  always_comb begin
    sat_nxt = 1'b0;
    rot_nxt = r[31:0];
    if (r > 36'sd2147483647) begin
      rot_nxt = 32'sh7fffffff;
      sat_nxt = 1'b1;
    end else if (r < -36'sd2147483648) begin
      rot_nxt = 32'sh80000000;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= 64'(m0) * 64'(v0);
      p1_r <= 64'(m1) * 64'(v1);
      p2_r <= 64'(m2) * 64'(v2);
      rot_r <= rot_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign rot = rot_r;
  assign sat = sat_r;
endmodule
